### sv/ita2_pkg.sv
// ----------------------------------------------------------------------------
// ita2_pkg
// Shared types and constants for the ITA-2 shift codec.
// ----------------------------------------------------------------------------
package ita2_pkg;

  localparam int TABLE_COUNT_DEF = 4;
  localparam int CODES_PER_SHIFT = 32;
  localparam int PAIR_SIZE       = 2 * CODES_PER_SHIFT;

  // item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  // ITA-2 special codes
  localparam logic [4:0] SHIFT_FIGS = 5'h1B;
  localparam logic [4:0] SHIFT_LTRS = 5'h1F;
  localparam logic [4:0] CODE_SPACE = 5'h04;

  // register index (byte address bit 2)
  localparam logic REG_UNSHIFT = 1'b0;
  localparam logic REG_TSEL    = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] table_address;
    logic [7:0] table_byte;
    logic [7:0] ascii_char;
    logic [4:0] baudot_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_shift;
    logic       last;
  } out_item_t;

endpackage

### sv/ita2_ram.sv
// ----------------------------------------------------------------------------
// ita2_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ita2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/ita2_shift_codec.sv
// ----------------------------------------------------------------------------
// ita2_shift_codec
// ITA-2 teletype codec with loadable letter/figure tables in one RAM.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ---------------------------------
//  input     in_data                        accepted when start & !busy
//  result    out_data                       out_valid strobe, one cycle each
//  config    psel penable pwrite paddr ...  APB write, pready tied high
//
// A load writes the RAM directly and busy stays low; a shift-code decode answers
// the next cycle without raising busy; other decodes hold busy in ST_DREAD for the
// RAM read. An encode holds busy while ST_SCAN scans the 32 positions on both RAM
// read ports, then ST_FINISH sends the result, or a shift code and ST_EMIT2 the code.
// Reset clears control state and configuration registers; table RAM stays undefined until
// loaded (no clearing pass). Results cannot be stalled.
//
module ita2_shift_codec
  import ita2_pkg::*;
#(
  parameter int TABLE_COUNT = ita2_pkg::TABLE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // command interface
  input  logic                start,
  output logic                busy,
  input  ita2_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ita2_pkg::out_item_t out_data,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int STORE_SIZE = TABLE_COUNT * PAIR_SIZE;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DREAD,   // decode: RAM data arrives
    ST_SCAN,    // encode: stream 32 positions
    ST_FINISH,  // encode: decide on shift / code
    ST_EMIT2    // encode: code after inserted shift
  } state_t;

  state_t    state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [7:0] char_r, char_nxt;
  logic       found_r, found_nxt;
  logic       figs_r, figs_nxt;
  logic [4:0] code_r, code_nxt;
  logic       tx_fig_r, tx_fig_nxt;
  logic       rx_fig_r, rx_fig_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  // configuration registers
  logic       uos_r;
  logic [1:0] tsel_r;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, raddr_a, raddr_b;
  logic [7:0]        rdata_a, rdata_b;

  logic [1:0]        tsel_wrap;
  logic [31:0]       base_full;
  logic [ADDR_W-1:0] pair_base;
  logic              accept;
  logic [7:0]        fold_char;
  logic              rx_new;
  logic [4:0]        scan_idx;

  // --------------------------------------------------------------------------
  // APB: write on access phase, index from byte address bit 2
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_UNSHIFT: prdata = {31'd0, uos_r};
      REG_TSEL:    prdata = {30'd0, tsel_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uos_r  <= 1'b0;
      tsel_r <= 2'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_UNSHIFT: uos_r  <= pwdata[0];
        REG_TSEL:    tsel_r <= pwdata[1:0];
        default:     ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Table RAM: letters on port A, figures on port B during a scan
  // --------------------------------------------------------------------------
  // table index wraps modulo the table count (at most three subtractions)
  always_comb begin
    tsel_wrap = tsel_r;
    for (int k = 0; k < 3; k++) begin
      if (32'(tsel_wrap) >= TABLE_COUNT) begin
        tsel_wrap = tsel_wrap - 2'(TABLE_COUNT);
      end
    end
  end

  assign base_full = 32'(tsel_wrap) * PAIR_SIZE;
  assign pair_base = base_full[ADDR_W-1:0];

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // lower case folds to upper case
  assign fold_char = (in_data.ascii_char >= 8'h61 && in_data.ascii_char <= 8'h7A) ?
                     in_data.ascii_char - 8'd32 : in_data.ascii_char;

  // space may return the receive side to letters before the lookup
  assign rx_new = (uos_r && in_data.baudot_code == CODE_SPACE) ? 1'b0 : rx_fig_r;

  assign ram_we    = accept && in_data.mode == MODE_LOAD &&
                     32'(in_data.table_address) < STORE_SIZE;
  assign ram_waddr = ADDR_W'(in_data.table_address);

  always_comb begin
    if (state_r == ST_IDLE) begin
      raddr_a = pair_base + ADDR_W'({rx_new, in_data.baudot_code});
    end else begin
      raddr_a = pair_base + ADDR_W'(cnt_r[4:0]);
    end
    raddr_b = pair_base + ADDR_W'({1'b1, cnt_r[4:0]});
  end

  ita2_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_data.table_byte),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // data on the read ports belongs to the position issued in the previous cycle
  assign scan_idx = cnt_r[4:0] - 5'd1;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    char_nxt      = char_r;
    found_nxt     = found_r;
    figs_nxt      = figs_r;
    code_nxt      = code_r;
    tx_fig_nxt    = tx_fig_r;
    rx_fig_nxt    = rx_fig_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.mode)
            MODE_ENCODE: begin
              // null character gives no transaction
              if (fold_char != 8'd0) begin
                char_nxt  = fold_char;
                cnt_nxt   = 6'd0;
                found_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            MODE_DECODE: begin
              if (in_data.baudot_code == SHIFT_FIGS ||
                  in_data.baudot_code == SHIFT_LTRS) begin
                rx_fig_nxt    = (in_data.baudot_code == SHIFT_FIGS);
                out_valid_nxt = 1'b1;
                out_nxt       = '{out_byte: 8'd0, is_shift: 1'b0, last: 1'b1};
              end else begin
                rx_fig_nxt = rx_new;
                state_nxt  = ST_DREAD;
              end
            end
            default: ;  // loads write the RAM directly; unused mode ignored
          endcase
        end
      end

      ST_DREAD: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{out_byte: rdata_a, is_shift: 1'b0, last: 1'b1};
        state_nxt     = ST_IDLE;
      end

      ST_SCAN: begin
        // last match wins; letters tried before figures at each position
        if (cnt_r != 6'd0) begin
          if (rdata_a == char_r) begin
            found_nxt = 1'b1;
            figs_nxt  = 1'b0;
            code_nxt  = scan_idx;
          end else if (rdata_b == char_r) begin
            found_nxt = 1'b1;
            figs_nxt  = 1'b1;
            code_nxt  = scan_idx;
          end
        end
        if (cnt_r == 6'(CODES_PER_SHIFT)) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      ST_FINISH: begin
        state_nxt = ST_IDLE;
        // no match, or final match at code 0: nothing sent, state kept
        if (found_r && code_r != 5'd0) begin
          out_valid_nxt = 1'b1;
          if (figs_r != tx_fig_r) begin
            tx_fig_nxt = figs_r;
            out_nxt    = '{out_byte: {3'd0, figs_r ? SHIFT_FIGS : SHIFT_LTRS},
                           is_shift: 1'b1, last: 1'b0};
            state_nxt  = ST_EMIT2;
          end else begin
            out_nxt = '{out_byte: {3'd0, code_r}, is_shift: 1'b0, last: 1'b1};
          end
        end
      end

      ST_EMIT2: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{out_byte: {3'd0, code_r}, is_shift: 1'b0, last: 1'b1};
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tx_fig_r    <= 1'b0;
      rx_fig_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tx_fig_r    <= tx_fig_nxt;
      rx_fig_r    <= rx_fig_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
    end
    char_r <= char_nxt;
    figs_r <= figs_nxt;
    code_r <= code_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an inserted shift code is always followed by the closing code transaction
  a_shift_then_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |=> out_valid_r && out_r.last && !out_r.is_shift)
    else $error("shift code not followed by final code");

  // shift code sent matches the transmit shift it switched to
  a_shift_matches_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_shift |->
      ((out_r.out_byte == {3'd0, SHIFT_FIGS}) == tx_fig_r))
    else $error("shift code disagrees with transmit shift");

  // a load never produces a result transaction
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.mode == MODE_LOAD |=> !out_valid_r)
    else $error("result after load");

endmodule
